### sv/brd_pkg.sv
// Shared types and constants for the byte ring deque.
`default_nettype none
package brd_pkg;

	localparam int IDX_W  = 10;
	localparam int DEPTH  = 1 << IDX_W;
	localparam int POS_W  = 16;
	localparam int STEP_W = $clog2(POS_W);
	localparam logic [IDX_W-1:0] CNT_MAX = IDX_W'(DEPTH - 1);

	typedef enum logic [2:0] {
		MODE_PUSH_BACK  = 3'd0,
		MODE_PUSH_FRONT = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_PEEK       = 3'd4,
		MODE_OVERWRITE  = 3'd5,
		MODE_CONSUME    = 3'd6,
		MODE_CLEAR      = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		mode_t             mode;
		logic [7:0]        data_in;
		logic [POS_W-1:0]  position;
		logic [9:0]        amount;
	} req_t;

	typedef struct packed {
		logic [7:0]        data_out;
		status_t           status;
		logic [9:0]        fill_count;
		logic [9:0]        free_room;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request
		logic exec;      // run the operation, start modulo if needed
		logic div_step;  // one remainder bit
		logic access;    // offset peek or overwrite at the computed slot
		logic resp;      // load response register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

### sv/brd_ctrl.sv
// Controller state machine for the byte ring deque.
`default_nettype none
module brd_ctrl
	import brd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_DIV    = 5'b00100,
		S_ACCESS = 5'b01000,
		S_RESP   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.need_div ? S_DIV : S_RESP;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_ACCESS;
				end
			end
			S_ACCESS: begin
				cmd.access = 1'b1;
				state_d    = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.resp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### sv/brd_dp.sv
// Datapath for the byte ring deque: indices, byte store, modulo unit, response register.
`default_nettype none
module brd_dp
	import brd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire cmd_t cmd,
	output sts_t      sts,
	input  wire logic rsp_stall,
	output logic      rsp_valid,
	output rsp_t      rsp
);

	logic [7:0]       mem_q [DEPTH];
	logic [7:0]       rd_q;
	req_t             item_q;
	logic [IDX_W-1:0] front_q, back_q, front_d, back_d;
	status_t          st_q, st_d;
	logic             use_rd_q, use_rd_d;
	logic [IDX_W-1:0] rem_q;
	logic [POS_W-1:0] pos_sh_q;
	logic [STEP_W-1:0] step_q;
	logic             out_valid_q;
	rsp_t             out_q;

	logic [IDX_W-1:0] cnt, slot, mem_addr;
	logic             full, empty, mem_we, mem_re;
	logic [IDX_W:0]   trial, trial_sub;

	assign cnt   = back_q - front_q;
	assign full  = (cnt == CNT_MAX);
	assign empty = (cnt == '0);
	assign slot  = front_q + rem_q;

	// restoring remainder, one position bit per cycle
	assign trial     = {rem_q, pos_sh_q[POS_W-1]};
	assign trial_sub = trial - {1'b0, cnt};

	assign sts.need_div = ((item_q.mode == MODE_PEEK) || (item_q.mode == MODE_OVERWRITE)) && !empty;
	assign sts.div_last = (step_q == STEP_W'(POS_W - 1));
	assign sts.out_free = !out_valid_q || !rsp_stall;

	always_comb begin
		front_d  = front_q;
		back_d   = back_q;
		st_d     = st_q;
		use_rd_d = use_rd_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = front_q;
		if (cmd.exec) begin
			st_d     = ST_DONE;
			use_rd_d = 1'b0;
			case (item_q.mode)
				MODE_PUSH_BACK: begin
					if (full) begin
						st_d = ST_FULL;
					end else begin
						mem_we   = 1'b1;
						mem_addr = back_q;
						back_d   = back_q + 1'b1;
					end
				end
				MODE_PUSH_FRONT: begin
					if (full) begin
						st_d = ST_FULL;
					end else begin
						mem_we   = 1'b1;
						mem_addr = front_q - 1'b1;
						front_d  = front_q - 1'b1;
					end
				end
				MODE_POP_FRONT: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						mem_re   = 1'b1;
						use_rd_d = 1'b1;
						mem_addr = front_q;
						front_d  = front_q + 1'b1;
					end
				end
				MODE_POP_BACK: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						mem_re   = 1'b1;
						use_rd_d = 1'b1;
						mem_addr = back_q - 1'b1;
						back_d   = back_q - 1'b1;
					end
				end
				MODE_PEEK, MODE_OVERWRITE: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end
				end
				MODE_CONSUME: begin
					front_d = front_q + ((item_q.amount < cnt) ? item_q.amount : cnt);
				end
				default: begin
					front_d = '0;
					back_d  = '0;
				end
			endcase
		end
		if (cmd.access) begin
			mem_addr = slot;
			if (item_q.mode == MODE_PEEK) begin
				mem_re   = 1'b1;
				use_rd_d = 1'b1;
			end else begin
				mem_we = 1'b1;
			end
		end
	end

	// byte store, single port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= item_q.data_in;
		end
		if (mem_re) begin
			rd_q <= mem_q[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
		if (cmd.exec) begin
			rem_q    <= '0;
			pos_sh_q <= item_q.position;
			step_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q    <= (trial >= {1'b0, cnt}) ? trial_sub[IDX_W-1:0] : trial[IDX_W-1:0];
			pos_sh_q <= {pos_sh_q[POS_W-2:0], 1'b0};
			step_q   <= step_q + 1'b1;
		end
		if (cmd.resp) begin
			out_q.data_out   <= use_rd_q ? rd_q : 8'd0;
			out_q.status     <= st_q;
			out_q.fill_count <= cnt;
			out_q.free_room  <= CNT_MAX - cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			back_q      <= '0;
			st_q        <= ST_DONE;
			use_rd_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			front_q  <= front_d;
			back_q   <= back_d;
			st_q     <= st_d;
			use_rd_q <= use_rd_d;
			if (cmd.resp) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

### sv/byte_ring_deque.sv
// Byte ring deque top level: 1024-byte circular store used as a double-ended queue.
// Push, pop, consume, clear, and peek or overwrite on an empty store go from the
// execute state to the response state. Peek and overwrite on a non-empty store also
// run the bit-serial remainder unit (16 steps of position mod count) and an access
// state. No new request is taken before the last one loads the response register.
// Reset clears both indices and the response valid flag; the byte store is not cleared
// and needs no sweep, so requests are taken from the first cycle after reset.
`default_nettype none
module byte_ring_deque
	import brd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	// Controller sequences each request; the datapath owns all state that
	// the request touches. The response register lets a new request start
	// while an earlier response is still stalled downstream.
	cmd_t cmd;
	sts_t sts;

	brd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	brd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	// a stalled response is never replaced
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp |-> !(rsp_valid && rsp_stall))
		else $error("response overwritten while stalled");

	// after taking a request the block is busy
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> req_stall)
		else $error("request taken while busy");

	// a refused push only happens with a full store
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_FULL) |-> (rsp.fill_count == CNT_MAX))
		else $error("full status with room left");

	// count and room always add up to capacity
	a_room_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (IDX_W'(rsp.fill_count + rsp.free_room) == CNT_MAX))
		else $error("fill count and free room disagree");
`endif

endmodule
`default_nettype wire
